>>> sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared geometry, cell codes and screen-store request type for the text
// console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int COPY_N  = (ROWS - 1) * COLUMNS;

  // Port field widths
  localparam int ROW_FW  = 5;
  localparam int COL_FW  = 7;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = ATTR_W + CHAR_W;

  // Internal widths
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CUR_ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WR_ROW_W   = $clog2(ROWS + 1);

  // Codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd244;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [ATTR_W-1:0] attr);
    return {attr, ch};
  endfunction

endpackage

>>> sv/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text-mode console: 80x25 screen of attribute/character cells with write
// position, line wrap, scroll on demand and single-cell read-back.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  cfg     | cfg_we_i, cfg_wdata_i                    | in
//  in      | in_valid_i/in_ready_o, opcode_i,         | in
//          | char_code_i, read_row_i, read_col_i      |
//  out     | out_valid_o/out_ready_i, cell_value_o,   | out
//          | cursor_row_o, cursor_col_o               |
//
// A put or a read is a transfer, then a result load (a read uses the
// store's registered read port in between).
// A scroll walks the store one cell a cycle: a put that scrolls goes through the
// sweep, the tail write and the put state; a newline with a scroll pending skips the put.
// After reset a clearing pass over every cell holds in_ready_o low.
// A stalled output holds the sequencer in its final state until the transfer.
// ----------------------------------------------------------------------------
module text_console_cell_writer import tccw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [ROW_FW-1:0] read_row_i,
  input  logic [COL_FW-1:0] read_col_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CELL_W-1:0] cell_value_o,
  output logic [ROW_FW-1:0] cursor_row_o,
  output logic [COL_FW-1:0] cursor_col_o
);

  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rdata;

  tccw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_value_o (cell_value_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  tccw_screen_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // One item at a time: a transfer drops ready
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  // Store writes stay inside the screen
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> mem_req.waddr < ADDR_W'(CELLS))
    else $error("screen write out of range");

  // Sweep never reads the cell it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we && mem_req.re |-> mem_req.waddr != mem_req.raddr)
    else $error("read and write to the same cell");

  // Reported cursor is always on screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_row_o < ROWS) && (cursor_col_o < COLUMNS))
    else $error("cursor off screen");

endmodule

>>> sv/tccw_screen_ram.sv
// ----------------------------------------------------------------------------
// tccw_screen_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tccw_screen_ram import tccw_pkg::*; (
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer for the console: clearing pass, put and read handling, scroll
// sweep over the screen store, write position, cursor and result register.
// ----------------------------------------------------------------------------
module tccw_ctrl import tccw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [ROW_FW-1:0] read_row_i,
  input  logic [COL_FW-1:0] read_col_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CELL_W-1:0] cell_value_o,
  output logic [ROW_FW-1:0] cursor_row_o,
  output logic [COL_FW-1:0] cursor_col_o,
  output mem_req_t          mem_req_o,
  input  logic [CELL_W-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_TAIL,
    ST_PUT,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [ADDR_W-1:0]     sweep_q, sweep_d;
  logic                  pend_valid_q, pend_valid_d;
  logic                  pend_copy_q, pend_copy_d;
  logic [ADDR_W-1:0]     pend_addr_q, pend_addr_d;
  logic [ATTR_W-1:0]     attr_q, attr_d;
  logic [WR_ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic [CUR_ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]      cur_col_q, cur_col_d;
  logic [CHAR_W-1:0]     char_q, char_d;
  logic                  nl_q, nl_d;
  logic                  rd_q, rd_d;
  logic                  hit_q, hit_d;
  logic                  out_valid_q, out_valid_d;
  logic [CELL_W-1:0]     cell_q, cell_d;
  logic [ROW_FW-1:0]     out_row_q, out_row_d;
  logic [COL_FW-1:0]     out_col_q, out_col_d;

  logic                  accept;
  logic                  on_screen;
  logic [COL_W:0]        col_inc;
  logic                  col_wrap;
  logic [WR_ROW_W-1:0]   row_inc;
  logic                  read_hit;

  assign accept    = in_valid_i && in_ready_o;
  assign on_screen = (row_q < WR_ROW_W'(ROWS));
  assign col_inc   = {1'b0, col_q} + 1'b1;
  assign col_wrap  = (col_inc >= (COL_W + 1)'(COLUMNS));
  assign row_inc   = row_q + 1'b1;
  assign read_hit  = (read_row_i < ROWS) && (read_col_i < COLUMNS);

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    pend_valid_d = pend_valid_q;
    pend_copy_d  = pend_copy_q;
    pend_addr_d  = pend_addr_q;
    attr_d       = cfg_we_i ? cfg_wdata_i : attr_q;
    row_d        = row_q;
    col_d        = col_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    char_d       = char_q;
    nl_d         = nl_q;
    rd_d         = rd_q;
    hit_d        = hit_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cell_d       = cell_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;

    mem_req_o = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = sweep_q;
        mem_req_o.wdata = make_cell(BLANK_CODE, ATTR_RESET);
        if (sweep_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          rd_d    = (opcode_i == OP_READ);
          hit_d   = 1'b0;
          char_d  = char_code_i;
          nl_d    = (char_code_i == NEWLINE_CODE);
          sweep_d = '0;
          if (opcode_i == OP_READ) begin
            hit_d         = read_hit;
            mem_req_o.re  = read_hit;
            mem_req_o.raddr = ADDR_W'(read_row_i * COLUMNS + read_col_i);
            state_d       = ST_DONE;
          end else if (!on_screen) begin
            // Pending scroll: sweep the store before finishing
            pend_valid_d = 1'b0;
            state_d      = ST_SCROLL;
          end else if (char_code_i == NEWLINE_CODE) begin
            row_d = row_inc;
            col_d = '0;
            if (row_inc < WR_ROW_W'(ROWS)) begin
              cur_row_d = CUR_ROW_W'(row_inc);
              cur_col_d = '0;
            end
            state_d = ST_DONE;
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = ADDR_W'(row_q * COLUMNS + col_q);
            mem_req_o.wdata = make_cell(char_code_i, attr_q);
            if (col_wrap) begin
              row_d = row_inc;
              col_d = '0;
              if (row_inc < WR_ROW_W'(ROWS)) begin
                cur_row_d = CUR_ROW_W'(row_inc);
                cur_col_d = '0;
              end
            end else begin
              col_d     = COL_W'(col_inc);
              cur_row_d = CUR_ROW_W'(row_q);
              cur_col_d = COL_W'(col_inc);
            end
            state_d = ST_DONE;
          end
        end
      end

      ST_SCROLL: begin
        // Read one row ahead; each slot is written in the cycle after its read
        mem_req_o.re    = (sweep_q < ADDR_W'(COPY_N));
        mem_req_o.raddr = ADDR_W'(sweep_q + COLUMNS);
        mem_req_o.we    = pend_valid_q;
        mem_req_o.waddr = pend_addr_q;
        mem_req_o.wdata = pend_copy_q ? mem_rdata_i : make_cell(BLANK_CODE, attr_q);
        pend_valid_d    = 1'b1;
        pend_addr_d     = sweep_q;
        pend_copy_d     = (sweep_q < ADDR_W'(COPY_N));
        if (sweep_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_TAIL;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      ST_TAIL: begin
        mem_req_o.we    = pend_valid_q;
        mem_req_o.waddr = pend_addr_q;
        mem_req_o.wdata = pend_copy_q ? mem_rdata_i : make_cell(BLANK_CODE, attr_q);
        pend_valid_d    = 1'b0;
        if (nl_q) begin
          // Scroll stays pending, cursor holds
          col_d   = '0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_PUT;
        end
      end

      ST_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ADDR_W'((ROWS - 1) * COLUMNS + col_q);
        mem_req_o.wdata = make_cell(char_q, attr_q);
        if (col_wrap) begin
          row_d = WR_ROW_W'(ROWS);
          col_d = '0;
        end else begin
          row_d     = WR_ROW_W'(ROWS - 1);
          col_d     = COL_W'(col_inc);
          cur_row_d = CUR_ROW_W'(ROWS - 1);
          cur_col_d = COL_W'(col_inc);
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          cell_d      = (rd_q && hit_q) ? mem_rdata_i : '0;
          out_row_d   = ROW_FW'(cur_row_q);
          out_col_d   = COL_FW'(cur_col_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      sweep_q      <= '0;
      pend_valid_q <= 1'b0;
      attr_q       <= ATTR_RESET;
      row_q        <= '0;
      col_q        <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      pend_valid_q <= pend_valid_d;
      attr_q       <= attr_d;
      row_q        <= row_d;
      col_q        <= col_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_copy_q <= pend_copy_d;
    pend_addr_q <= pend_addr_d;
    char_q      <= char_d;
    nl_q        <= nl_d;
    rd_q        <= rd_d;
    hit_q       <= hit_d;
    cell_q      <= cell_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cell_value_o = cell_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console cell writer. A queue-fed driver
// sends put and read operations and a shadow screen with write position and
// cursor predicts every result. A monitor compares each result field by field.
// The stimulus runs through several text attributes: directed corner cases
// first, then random text, newline bursts that scroll past the bottom, and
// reads on and off the screen.
// ----------------------------------------------------------------------------
module testbench;
  import tccw_pkg::*;

  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 6;
  localparam int REPORT_MAX    = 10;
  localparam int PHASE_ITEMS   = 334;
  localparam int ITEM_BUDGET   = 24;
  localparam int SCROLL_BUDGET = CELLS + 10;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic              opcode;
    logic [CHAR_W-1:0] ch;
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] col;
  } console_op_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [ROW_FW-1:0] crow;
    logic [COL_FW-1:0] ccol;
  } cell_view_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              opcode_i    = OP_PUT;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [ROW_FW-1:0] read_row_i  = '0;
  logic [COL_FW-1:0] read_col_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CELL_W-1:0] cell_value_o;
  logic [ROW_FW-1:0] cursor_row_o;
  logic [COL_FW-1:0] cursor_col_o;

  text_console_cell_writer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_value_o (cell_value_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow console
  logic [CELL_W-1:0] shadow_screen [CELLS];
  logic [ATTR_W-1:0] shadow_attr;
  int                shadow_row;
  int                shadow_col;
  int                shadow_cursor;

  console_op_t pending_ops[$];
  cell_view_t  awaited_views[$];

  bit calm = 1'b0;
  int cycle_count = 0;
  int cycle_limit = 4 * (CELLS + RESET_CYCLES) + 20000;
  int planned_items = 0;
  int planned_newlines = 0;
  int planned_chars = 0;

  int mismatches = 0;
  int results_seen = 0;
  int put_count = 0;
  int newline_count = 0;
  int read_count = 0;
  int offscreen_reads = 0;
  int scroll_count = 0;
  int attr_settings = 1;

  task automatic scroll_shadow();
    for (int i = 0; i < COPY_N; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
    for (int i = COPY_N; i < CELLS; i++) shadow_screen[i] = {shadow_attr, BLANK_CODE};
    scroll_count++;
  endtask

  task automatic console_apply(input console_op_t op, output cell_view_t view);
    view.cell_val = '0;
    if (op.opcode == OP_READ) begin
      read_count++;
      if (op.row < ROWS && op.col < COLUMNS) begin
        view.cell_val = shadow_screen[op.row * COLUMNS + op.col];
      end else begin
        offscreen_reads++;
      end
    end else begin
      put_count++;
      if (op.ch == NEWLINE_CODE) begin
        newline_count++;
        // a newline with a scroll pending scrolls at once and stays pending
        if (shadow_row >= ROWS) begin
          scroll_shadow();
        end else begin
          shadow_row++;
        end
        shadow_col = 0;
      end else begin
        if (shadow_row >= ROWS) begin
          scroll_shadow();
          shadow_row = ROWS - 1;
        end
        shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, op.ch};
        shadow_col++;
        if (shadow_col >= COLUMNS) begin
          shadow_col = 0;
          shadow_row++;
        end
      end
      // hold the cursor at its last on-screen spot while off the bottom
      if (shadow_row < ROWS) shadow_cursor = shadow_row * COLUMNS + shadow_col;
    end
    view.crow = ROW_FW'(shadow_cursor / COLUMNS);
    view.ccol = COL_FW'(shadow_cursor % COLUMNS);
  endtask

  task automatic queue_put(input logic [CHAR_W-1:0] ch);
    console_op_t op;
    op.opcode = OP_PUT;
    op.ch     = ch;
    op.row    = ROW_FW'($urandom_range(0, (1 << ROW_FW) - 1));
    op.col    = COL_FW'($urandom_range(0, (1 << COL_FW) - 1));
    pending_ops.push_back(op);
    planned_items++;
    if (ch == NEWLINE_CODE) planned_newlines++;
    else planned_chars++;
  endtask

  task automatic queue_read(input int row, input int col);
    console_op_t op;
    op.opcode = OP_READ;
    op.ch     = CHAR_W'($urandom_range(0, (1 << CHAR_W) - 1));
    op.row    = ROW_FW'(row);
    op.col    = COL_FW'(col);
    pending_ops.push_back(op);
    planned_items++;
  endtask

  task automatic queue_random(input int n);
    int added;
    int r;
    int len;
    logic [CHAR_W-1:0] ch;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // newline burst: reach the bottom and scroll on further newlines
        len = $urandom_range(2, ROWS + 2);
        repeat (len) queue_put(NEWLINE_CODE);
        added += len;
      end else if (r < 10) begin
        // text run of up to COLUMNS + 20 characters, at times long enough to wrap a row
        len = $urandom_range(1, COLUMNS + 20);
        repeat (len) begin
          do ch = CHAR_W'($urandom_range(0, (1 << CHAR_W) - 1));
          while (ch == NEWLINE_CODE);
          queue_put(ch);
        end
        added += len;
      end else if (r < 16) begin
        queue_put(NEWLINE_CODE);
        added++;
      end else if (r < 55) begin
        queue_put(CHAR_W'($urandom_range(0, (1 << CHAR_W) - 1)));
        added++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          queue_read($urandom_range(0, (1 << ROW_FW) - 1), $urandom_range(0, (1 << COL_FW) - 1));
        end else if (r < 40) begin
          queue_read($urandom_range(ROWS - 3, ROWS - 1), $urandom_range(0, COLUMNS - 1));
        end else begin
          queue_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
        end
        added++;
      end
    end
  endtask

  // Extend the cycle limit by this phase's worst case, then wait for it to drain.
  task automatic drain_phase();
    cycle_limit += 4 * (planned_items * ITEM_BUDGET +
                        (planned_newlines + planned_chars / COLUMNS + 2) * SCROLL_BUDGET);
    planned_items    = 0;
    planned_newlines = 0;
    planned_chars    = 0;
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || awaited_views.size() != 0);
  endtask

  task automatic program_attr(input logic [ATTR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_attr = value;
    attr_settings++;
    @(negedge clk_i);
  endtask

  // Driver: present the next operation once the current one has transferred
  console_op_t sent_op;
  console_op_t next_op;
  cell_view_t  predicted;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        sent_op = '{opcode_i, char_code_i, read_row_i, read_col_i};
        console_apply(sent_op, predicted);
        awaited_views.push_back(predicted);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_op = pending_ops.pop_front();
          opcode_i    <= next_op.opcode;
          char_code_i <= next_op.ch;
          read_row_i  <= next_op.row;
          read_col_i  <= next_op.col;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and check each result transfer
  cell_view_t wanted;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (awaited_views.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result %0d with nothing outstanding: cell %h cursor %0d,%0d",
                     results_seen, cell_value_o, cursor_row_o, cursor_col_o);
        end else begin
          wanted = awaited_views.pop_front();
          if (cell_value_o !== wanted.cell_val || cursor_row_o !== wanted.crow ||
              cursor_col_o !== wanted.ccol) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("result %0d: expected cell %h cursor %0d,%0d, got cell %h cursor %0d,%0d",
                       results_seen, wanted.cell_val, wanted.crow, wanted.ccol,
                       cell_value_o, cursor_row_o, cursor_col_o);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < cycle_limit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    shadow_attr   = ATTR_RESET;
    shadow_row    = 0;
    shadow_col    = 0;
    shadow_cursor = 0;
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = {ATTR_RESET, BLANK_CODE};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset contents, off-screen reads, extreme codes, newline
    queue_read(0, 0);
    queue_read(ROWS - 1, COLUMNS - 1);
    queue_read(ROWS, 0);
    queue_read(0, COLUMNS);
    queue_read((1 << ROW_FW) - 1, (1 << COL_FW) - 1);
    queue_put('0);
    queue_put('1);
    queue_put(NEWLINE_CODE);
    queue_put(BLANK_CODE);
    queue_read(0, 0);
    queue_read(0, 1);
    queue_read(1, 0);
    queue_read(0, 2);
    drain_phase();

    // Old cells keep their colour after the attribute changes
    program_attr('0);
    queue_read(0, 0);
    queue_random(PHASE_ITEMS);
    drain_phase();

    calm = 1'b1;
    program_attr('1);
    queue_random(PHASE_ITEMS);
    drain_phase();
    calm = 1'b0;

    program_attr(ATTR_W'($urandom_range(0, (1 << ATTR_W) - 1)));
    queue_random(PHASE_ITEMS);
    drain_phase();

    program_attr(ATTR_W'($urandom_range(0, (1 << ATTR_W) - 1)));
    queue_random(PHASE_ITEMS);
    drain_phase();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d results: %0d puts (%0d newlines), %0d reads (%0d off screen)",
             results_seen, put_count, newline_count, read_count, offscreen_reads);
    $display("%0d scrolls under %0d attribute settings in %0d cycles",
             scroll_count, attr_settings, cycle_count);
    if (mismatches == 0 && awaited_views.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> text_console_cell_writer.f
sv/tccw_pkg.sv
sv/tccw_screen_ram.sv
sv/tccw_ctrl.sv
sv/text_console_cell_writer.sv
tb/testbench.sv
